// ----- rtl/core/ept_pkg.sv -----
// ----------------------------------------------------------------------------
// ept_pkg: shared types and constants of the encoder tracker
// Item record, configuration register indexes, sequencer states and the
// velocity saturation function.
// ----------------------------------------------------------------------------
package ept_pkg;

	localparam int READING_W     = 16;
	localparam int OFFSET_W      = 16;
	localparam int TABLE_AW      = 7;
	localparam int TABLE_ENTRIES = 128;
	localparam int FRAC_W        = 9;
	localparam int COUNT_W       = 18;
	localparam int ANGLE_W       = 16;
	localparam int TURN_W        = 16;
	localparam int POS_W         = 32;
	localparam int DELTA_W       = 33;
	localparam int PROD_W        = 50;
	localparam int EVEL_W        = 58;
	localparam int VEL_W         = 32;
	localparam int PP_W          = 7;
	localparam int CFG_AW        = 3;
	localparam int CFG_DW        = 32;
	localparam int QUEUE_DEPTH   = 2;
	localparam int QUEUE_AW      = 1;
	localparam int QUEUE_CW      = 2;
	localparam logic [CFG_DW-1:0] INV_TIME_RESET = 32'h0001_0000;

	typedef enum logic {
		KIND_SAMPLE      = 1'b0,
		KIND_TABLE_WRITE = 1'b1
	} kind_t;

	typedef enum logic [CFG_AW-1:0] {
		CFG_MECH_ZERO  = 3'd0,
		CFG_ELEC_ZERO  = 3'd1,
		CFG_POLE_PAIRS = 3'd2,
		CFG_DEADBAND   = 3'd3,
		CFG_INV_TIME   = 3'd4
	} cfg_reg_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_TURN,
		BK_DELTA,
		BK_MUL,
		BK_SUM,
		BK_DONE
	} back_state_t;

	typedef struct packed {
		kind_t                 kind;
		logic                  poll;
		logic [READING_W-1:0]  reading;
		logic [OFFSET_W-1:0]   offset;
	} work_t;

	function automatic logic [VEL_W-1:0] sat_vel(input logic signed [EVEL_W-1:0] x);
		logic [VEL_W-1:0] r;
		if (x > 58'sd2147483647) begin
			r = 32'h7FFF_FFFF;
		end else if (x < -58'sd2147483648) begin
			r = 32'h8000_0000;
		end else begin
			r = x[VEL_W-1:0];
		end
		return r;
	endfunction

endpackage

// ----- rtl/core/encoder_position_velocity_tracker.sv -----
// ----------------------------------------------------------------------------
// encoder_position_velocity_tracker: linearized multiturn encoder tracker
// Offset-table linearization, single-turn and electrical angle, turn count,
// multiturn position and windowed dead-banded velocity.
// ----------------------------------------------------------------------------
//  channel   handshake                 payload
//  input     push / full               func, poll_sensor, sensor_reading,
//                                      table_index, table_value
//  result    empty / pop               linear_count, mech_angle, electrical_angle,
//                                      turn_count, multiturn_position,
//                                      mech_velocity, electrical_velocity
//  config    cfg_we                    cfg_addr, cfg_wdata
//
//  The intake takes one beat a cycle while full is low; the table read is
//  registered and interpolated before an item enters a two-entry work queue.
//  The tracker sequencer steps a position sample through angle, rollover,
//  window difference, split multiply, sum and saturation, and answers a
//  table write straight from idle; no new sample starts before the last is done.
//  Reset clears the offset table through per-entry valid bits, no sweep.
//  A full result register stalls the tracker; a full queue stalls intake.
// ----------------------------------------------------------------------------
module encoder_position_velocity_tracker #(
	parameter int WINDOW_DEPTH = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                push,
	output logic                                full,
	input  logic                                func,
	input  logic                                poll_sensor,
	input  logic [ept_pkg::READING_W-1:0]       sensor_reading,
	input  logic [ept_pkg::TABLE_AW-1:0]        table_index,
	input  logic signed [ept_pkg::OFFSET_W-1:0] table_value,
	output logic                                empty,
	input  logic                                pop,
	output logic signed [ept_pkg::COUNT_W-1:0]  linear_count,
	output logic [ept_pkg::ANGLE_W-1:0]         mech_angle,
	output logic [ept_pkg::ANGLE_W-1:0]         electrical_angle,
	output logic signed [ept_pkg::TURN_W-1:0]   turn_count,
	output logic signed [ept_pkg::POS_W-1:0]    multiturn_position,
	output logic signed [ept_pkg::VEL_W-1:0]    mech_velocity,
	output logic signed [ept_pkg::VEL_W-1:0]    electrical_velocity,
	input  logic                                cfg_we,
	input  logic [ept_pkg::CFG_AW-1:0]          cfg_addr,
	input  logic [ept_pkg::CFG_DW-1:0]          cfg_wdata
);

	logic           fq_push;
	logic           fq_full;
	ept_pkg::work_t fq_item;
	logic           bq_pop;
	logic           bq_empty;
	ept_pkg::work_t bq_item;

	ept_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.func          (func),
		.poll_sensor   (poll_sensor),
		.sensor_reading(sensor_reading),
		.table_index   (table_index),
		.table_value   (table_value),
		.q_push        (fq_push),
		.q_full        (fq_full),
		.q_item        (fq_item)
	);

	ept_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (fq_push),
		.item_in (fq_item),
		.full    (fq_full),
		.pop     (bq_pop),
		.item_out(bq_item),
		.empty   (bq_empty)
	);

	ept_back #(
		.WINDOW_DEPTH(WINDOW_DEPTH)
	) u_back (
		.clk                (clk),
		.arst_n             (arst_n),
		.cfg_we             (cfg_we),
		.cfg_addr           (cfg_addr),
		.cfg_wdata          (cfg_wdata),
		.q_pop              (bq_pop),
		.q_empty            (bq_empty),
		.q_item             (bq_item),
		.pop                (pop),
		.empty              (empty),
		.linear_count       (linear_count),
		.mech_angle         (mech_angle),
		.electrical_angle   (electrical_angle),
		.turn_count         (turn_count),
		.multiturn_position (multiturn_position),
		.mech_velocity      (mech_velocity),
		.electrical_velocity(electrical_velocity)
	);

endmodule

// ----- rtl/core/ept_ram.sv -----
// ----------------------------------------------------------------------------
// ept_ram: generic single-port-write RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ept_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- rtl/core/ept_front.sv -----
// ----------------------------------------------------------------------------
// ept_front: intake and linearization
// Accepts items, writes the offset table, reads both neighbor entries and
// interpolates the offset before handing the item to the work queue.
// ----------------------------------------------------------------------------
module ept_front (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                push,
	output logic                                full,
	input  logic                                func,
	input  logic                                poll_sensor,
	input  logic [ept_pkg::READING_W-1:0]       sensor_reading,
	input  logic [ept_pkg::TABLE_AW-1:0]        table_index,
	input  logic signed [ept_pkg::OFFSET_W-1:0] table_value,
	output logic                                q_push,
	input  logic                                q_full,
	output ept_pkg::work_t                      q_item
);

	logic                                accept;
	logic [ept_pkg::TABLE_AW-1:0]        seg;
	logic [ept_pkg::TABLE_AW-1:0]        seg_next;
	logic [ept_pkg::TABLE_ENTRIES-1:0]   tvalid_q;
	logic [ept_pkg::OFFSET_W-1:0]        rd_lo;
	logic [ept_pkg::OFFSET_W-1:0]        rd_hi;
	logic                                valid_s1;
	logic                                func_s1;
	logic                                poll_s1;
	logic [ept_pkg::READING_W-1:0]       reading_s1;
	logic                                lo_ok_s1;
	logic                                hi_ok_s1;
	logic signed [ept_pkg::OFFSET_W-1:0] lo_v;
	logic signed [ept_pkg::OFFSET_W-1:0] hi_v;
	logic signed [16:0]                  diff;
	logic signed [26:0]                  prod;
	logic signed [26:0]                  step;
	logic [ept_pkg::OFFSET_W-1:0]        offset;

	assign full     = valid_s1 && q_full;
	assign accept   = push && !full;
	assign seg      = sensor_reading[ept_pkg::READING_W-1:ept_pkg::FRAC_W];
	assign seg_next = seg + 1'b1;

	ept_ram #(
		.WIDTH(ept_pkg::OFFSET_W),
		.DEPTH(ept_pkg::TABLE_ENTRIES)
	) u_ram_lo (
		.clk  (clk),
		.we   (accept && func),
		.waddr(table_index),
		.wdata(table_value),
		.re   (accept && !func),
		.raddr(seg),
		.rdata(rd_lo)
	);

	ept_ram #(
		.WIDTH(ept_pkg::OFFSET_W),
		.DEPTH(ept_pkg::TABLE_ENTRIES)
	) u_ram_hi (
		.clk  (clk),
		.we   (accept && func),
		.waddr(table_index),
		.wdata(table_value),
		.re   (accept && !func),
		.raddr(seg_next),
		.rdata(rd_hi)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tvalid_q <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (accept && func) begin
				tvalid_q[table_index] <= 1'b1;
			end
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (q_push) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_s1    <= func;
			poll_s1    <= poll_sensor;
			reading_s1 <= sensor_reading;
			lo_ok_s1   <= tvalid_q[seg];
			hi_ok_s1   <= tvalid_q[seg_next];
		end
	end

	// unwritten entries read as zero
	assign lo_v   = lo_ok_s1 ? $signed(rd_lo) : '0;
	assign hi_v   = hi_ok_s1 ? $signed(rd_hi) : '0;
	assign diff   = 17'(hi_v) - 17'(lo_v);
	assign prod   = 27'(diff) * 27'($signed({1'b0, reading_s1[ept_pkg::FRAC_W-1:0]}));
	assign step   = prod >>> ept_pkg::FRAC_W;
	assign offset = lo_v + step[ept_pkg::OFFSET_W-1:0];

	assign q_push         = valid_s1 && !q_full;
	assign q_item.kind    = ept_pkg::kind_t'(func_s1);
	assign q_item.poll    = poll_s1;
	assign q_item.reading = reading_s1;
	assign q_item.offset  = offset;

endmodule

// ----- rtl/core/ept_queue.sv -----
// ----------------------------------------------------------------------------
// ept_queue: work queue between intake and tracker
// Two-entry FIFO of classified items.
// ----------------------------------------------------------------------------
module ept_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  ept_pkg::work_t item_in,
	output logic           full,
	input  logic           pop,
	output ept_pkg::work_t item_out,
	output logic           empty
);

	ept_pkg::work_t                mem_q [ept_pkg::QUEUE_DEPTH];
	logic [ept_pkg::QUEUE_AW-1:0]  wptr_q;
	logic [ept_pkg::QUEUE_AW-1:0]  rptr_q;
	logic [ept_pkg::QUEUE_CW-1:0]  count_q;
	logic                          do_push;
	logic                          do_pop;

	assign full     = count_q == ept_pkg::QUEUE_CW'(ept_pkg::QUEUE_DEPTH);
	assign empty    = count_q == '0;
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign item_out = mem_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (do_pop) begin
				rptr_q <= rptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wptr_q] <= item_in;
		end
	end

endmodule

// ----- rtl/core/ept_back.sv -----
// ----------------------------------------------------------------------------
// ept_back: angle, turn and velocity tracker
// Holds configuration, steps each sample through angle, rollover, window
// difference, split reciprocal multiply and saturation; owns the result
// register.
// ----------------------------------------------------------------------------
module ept_back #(
	parameter int WINDOW_DEPTH = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [ept_pkg::CFG_AW-1:0]          cfg_addr,
	input  logic [ept_pkg::CFG_DW-1:0]          cfg_wdata,
	output logic                                q_pop,
	input  logic                                q_empty,
	input  ept_pkg::work_t                      q_item,
	input  logic                                pop,
	output logic                                empty,
	output logic signed [ept_pkg::COUNT_W-1:0]  linear_count,
	output logic [ept_pkg::ANGLE_W-1:0]         mech_angle,
	output logic [ept_pkg::ANGLE_W-1:0]         electrical_angle,
	output logic signed [ept_pkg::TURN_W-1:0]   turn_count,
	output logic signed [ept_pkg::POS_W-1:0]    multiturn_position,
	output logic signed [ept_pkg::VEL_W-1:0]    mech_velocity,
	output logic signed [ept_pkg::VEL_W-1:0]    electrical_velocity
);

	ept_pkg::back_state_t state_q;
	ept_pkg::back_state_t state_d;

	logic [ept_pkg::ANGLE_W-1:0]         mech_zero_q;
	logic [ept_pkg::ANGLE_W-1:0]         elec_zero_q;
	logic [ept_pkg::PP_W-1:0]            pole_pairs_q;
	logic [ept_pkg::ANGLE_W-1:0]         deadband_q;
	logic [ept_pkg::CFG_DW-1:0]          inv_time_q;

	logic [ept_pkg::READING_W-1:0]       held_reading_q;
	logic [ept_pkg::OFFSET_W-1:0]        held_offset_q;
	logic [ept_pkg::ANGLE_W-1:0]         prev_angle_q;
	logic [ept_pkg::TURN_W-1:0]          turns_q;
	logic                                seen_q;
	logic signed [ept_pkg::POS_W-1:0]    win_q [WINDOW_DEPTH];

	logic signed [ept_pkg::COUNT_W-1:0]  count_q;
	logic [ept_pkg::ANGLE_W-1:0]         angle_q;
	logic [ept_pkg::ANGLE_W-1:0]         ediff_q;
	logic [ept_pkg::ANGLE_W-1:0]         eangle_q;
	logic [ept_pkg::POS_W-1:0]           mt_q;
	logic signed [ept_pkg::DELTA_W-1:0]  delta_q;
	logic signed [ept_pkg::PROD_W-1:0]   prod_hi_q;
	logic signed [ept_pkg::PROD_W-1:0]   prod_lo_q;
	logic signed [ept_pkg::PROD_W-1:0]   vel_q;
	logic                                out_valid_q;

	logic                                out_free;
	logic                                take_sample;
	logic                                ld_zero;
	logic                                ld_result;
	logic [ept_pkg::READING_W-1:0]       sel_reading;
	logic [ept_pkg::OFFSET_W-1:0]        sel_offset;
	logic signed [ept_pkg::COUNT_W-1:0]  count_n;
	logic [22:0]                         eprod;
	logic signed [16:0]                  dang;
	logic [ept_pkg::TURN_W-1:0]          turns_n;
	logic signed [ept_pkg::DELTA_W-1:0]  delta_n;
	logic signed [33:0]                  delta_w;
	logic signed [33:0]                  band_w;
	logic                                in_band;
	logic signed [ept_pkg::EVEL_W-1:0]   vel_w;
	logic signed [ept_pkg::EVEL_W-1:0]   evel;

	assign empty    = !out_valid_q;
	assign out_free = !out_valid_q || pop;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ept_pkg::BK_IDLE: begin
				if (!q_empty && q_item.kind == ept_pkg::KIND_SAMPLE) begin
					state_d = ept_pkg::BK_TURN;
				end
			end
			ept_pkg::BK_TURN:  state_d = ept_pkg::BK_DELTA;
			ept_pkg::BK_DELTA: state_d = ept_pkg::BK_MUL;
			ept_pkg::BK_MUL:   state_d = ept_pkg::BK_SUM;
			ept_pkg::BK_SUM:   state_d = ept_pkg::BK_DONE;
			ept_pkg::BK_DONE: begin
				if (out_free) begin
					state_d = ept_pkg::BK_IDLE;
				end
			end
			default: state_d = ept_pkg::BK_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		q_pop     = 1'b0;
		ld_result = 1'b0;
		case (state_q)
			ept_pkg::BK_IDLE: begin
				q_pop = !q_empty && (q_item.kind == ept_pkg::KIND_SAMPLE || out_free);
			end
			ept_pkg::BK_DONE: begin
				ld_result = out_free;
			end
			default: begin
				q_pop     = 1'b0;
				ld_result = 1'b0;
			end
		endcase
	end

	assign take_sample = q_pop && q_item.kind == ept_pkg::KIND_SAMPLE;
	assign ld_zero     = q_pop && q_item.kind == ept_pkg::KIND_TABLE_WRITE;

	assign sel_reading = q_item.poll ? q_item.reading : held_reading_q;
	assign sel_offset  = q_item.poll ? q_item.offset : held_offset_q;
	assign count_n     = $signed({2'b00, sel_reading}) + 18'($signed(sel_offset));

	assign eprod = ediff_q * pole_pairs_q;
	assign dang  = $signed({1'b0, angle_q}) - $signed({1'b0, prev_angle_q});

	always_comb begin
		turns_n = turns_q;
		if (dang > 17'sd32768) begin
			turns_n = turns_q - 1'b1;
		end else if (dang < -17'sd32768) begin
			turns_n = turns_q + 1'b1;
		end
		if (!seen_q) begin
			turns_n = '0;
		end
	end

	assign delta_n = ept_pkg::DELTA_W'(win_q[WINDOW_DEPTH-1]) - ept_pkg::DELTA_W'(win_q[0]);
	assign delta_w = 34'(delta_n);
	assign band_w  = $signed({18'd0, deadband_q});
	assign in_band = (delta_w < band_w) && (delta_w > -band_w);

	assign vel_w = ept_pkg::EVEL_W'(vel_q);
	assign evel  = vel_w * ept_pkg::EVEL_W'($signed({1'b0, pole_pairs_q}));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ept_pkg::BK_IDLE;
			mech_zero_q    <= '0;
			elec_zero_q    <= '0;
			pole_pairs_q   <= ept_pkg::PP_W'(1);
			deadband_q     <= '0;
			inv_time_q     <= ept_pkg::INV_TIME_RESET;
			held_reading_q <= '0;
			held_offset_q  <= '0;
			prev_angle_q   <= '0;
			turns_q        <= '0;
			seen_q         <= 1'b0;
			out_valid_q    <= 1'b0;
			for (int i = 0; i < WINDOW_DEPTH; i++) begin
				win_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				case (cfg_addr)
					ept_pkg::CFG_MECH_ZERO:  mech_zero_q  <= cfg_wdata[ept_pkg::ANGLE_W-1:0];
					ept_pkg::CFG_ELEC_ZERO:  elec_zero_q  <= cfg_wdata[ept_pkg::ANGLE_W-1:0];
					ept_pkg::CFG_POLE_PAIRS: pole_pairs_q <= cfg_wdata[ept_pkg::PP_W-1:0];
					ept_pkg::CFG_DEADBAND:   deadband_q   <= cfg_wdata[ept_pkg::ANGLE_W-1:0];
					ept_pkg::CFG_INV_TIME:   inv_time_q   <= cfg_wdata;
					default: begin
					end
				endcase
			end
			if (take_sample && q_item.poll) begin
				held_reading_q <= q_item.reading;
				held_offset_q  <= q_item.offset;
			end
			if (state_q == ept_pkg::BK_TURN) begin
				turns_q      <= turns_n;
				seen_q       <= 1'b1;
				prev_angle_q <= angle_q;
				for (int i = 0; i < WINDOW_DEPTH - 1; i++) begin
					win_q[i] <= win_q[i+1];
				end
				win_q[WINDOW_DEPTH-1] <= $signed({turns_n, angle_q});
			end
			if (ld_zero || ld_result) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_sample) begin
			count_q <= count_n;
			angle_q <= count_n[ept_pkg::ANGLE_W-1:0] - mech_zero_q;
			ediff_q <= count_n[ept_pkg::ANGLE_W-1:0] - elec_zero_q;
		end
		if (state_q == ept_pkg::BK_TURN) begin
			eangle_q <= eprod[ept_pkg::ANGLE_W-1:0];
			mt_q     <= {turns_n, angle_q};
		end
		if (state_q == ept_pkg::BK_DELTA) begin
			delta_q <= in_band ? '0 : delta_n;
		end
		if (state_q == ept_pkg::BK_MUL) begin
			prod_hi_q <= ept_pkg::PROD_W'(delta_q) *
				ept_pkg::PROD_W'($signed({1'b0, inv_time_q[31:16]}));
			prod_lo_q <= ept_pkg::PROD_W'(delta_q) *
				ept_pkg::PROD_W'($signed({1'b0, inv_time_q[15:0]}));
		end
		if (state_q == ept_pkg::BK_SUM) begin
			vel_q <= prod_hi_q + (prod_lo_q >>> 16);
		end
		if (ld_zero) begin
			linear_count        <= '0;
			mech_angle          <= '0;
			electrical_angle    <= '0;
			turn_count          <= '0;
			multiturn_position  <= '0;
			mech_velocity       <= '0;
			electrical_velocity <= '0;
		end else if (ld_result) begin
			linear_count        <= count_q;
			mech_angle          <= angle_q;
			electrical_angle    <= eangle_q;
			turn_count          <= turns_q;
			multiturn_position  <= mt_q;
			mech_velocity       <= ept_pkg::sat_vel(vel_w);
			electrical_velocity <= ept_pkg::sat_vel(evel);
		end
	end

endmodule

// ----- tb/tracker_check_pkg.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tracker_check_pkg: item records and result checker for the encoder tracker
// Keeps a bit-true copy of the table, held reading, turn counter and position
// history. Every accepted beat is turned into its expected report. Reports
// leaving the block are compared field by field, in order.
// ----------------------------------------------------------------------------
package tracker_check_pkg;

	import ept_pkg::*;

	localparam int HISTORY_DEPTH = 16;

	typedef struct {
		kind_t                       kind;
		logic                        poll;
		logic [READING_W-1:0]        reading;
		logic [TABLE_AW-1:0]         index;
		logic signed [OFFSET_W-1:0]  value;
	} tracker_item_t;

	typedef struct packed {
		logic signed [COUNT_W-1:0] linear_count;
		logic [ANGLE_W-1:0]        mech_angle;
		logic [ANGLE_W-1:0]        electrical_angle;
		logic signed [TURN_W-1:0]  turn_count;
		logic signed [POS_W-1:0]   multiturn_position;
		logic signed [VEL_W-1:0]   mech_velocity;
		logic signed [VEL_W-1:0]   electrical_velocity;
	} position_report_t;

	class position_checker;

		logic [ANGLE_W-1:0]         mech_zero;
		logic [ANGLE_W-1:0]         elec_zero;
		logic [PP_W-1:0]            pole_pairs;
		logic [ANGLE_W-1:0]         deadband;
		logic [CFG_DW-1:0]          inv_time;

		logic signed [OFFSET_W-1:0] offsets [TABLE_ENTRIES];
		logic [READING_W-1:0]       held_reading;
		logic signed [OFFSET_W-1:0] held_offset;
		logic [ANGLE_W-1:0]         last_angle;
		logic [TURN_W-1:0]          turns;
		bit                         primed;
		logic signed [POS_W-1:0]    history [HISTORY_DEPTH];

		position_report_t           expected_positions [$];
		int                         mismatches;

		function new();
			mech_zero    = '0;
			elec_zero    = '0;
			pole_pairs   = 7'd1;
			deadband     = '0;
			inv_time     = 32'h0001_0000;
			held_reading = '0;
			held_offset  = '0;
			last_angle   = '0;
			turns        = '0;
			primed       = 1'b0;
			mismatches   = 0;
			foreach (offsets[i]) offsets[i] = '0;
			foreach (history[i]) history[i] = '0;
		endfunction

		function void write_register(cfg_reg_t addr, logic [CFG_DW-1:0] data);
			case (addr)
				CFG_MECH_ZERO:  mech_zero  = data[ANGLE_W-1:0];
				CFG_ELEC_ZERO:  elec_zero  = data[ANGLE_W-1:0];
				CFG_POLE_PAIRS: pole_pairs = data[PP_W-1:0];
				CFG_DEADBAND:   deadband   = data[ANGLE_W-1:0];
				CFG_INV_TIME:   inv_time   = data;
				default: ;
			endcase
		endfunction

		function logic [VEL_W-1:0] clamp32(longint x);
			if (x > 64'sd2147483647) return 32'h7FFF_FFFF;
			if (x < -64'sd2147483648) return 32'h8000_0000;
			return x[VEL_W-1:0];
		endfunction

		function void accept_item(tracker_item_t it);
			position_report_t r;
			int               seg;
			int               d;
			longint           lo;
			longint           hi;
			longint           frac;
			longint           count;
			longint           delta;
			longint           mag;
			longint           vel;
			longint           evel;
			logic [15:0]      angle;
			logic [15:0]      eangle;
			logic [15:0]      t;
			logic [31:0]      mt;
			r = '0;
			if (it.kind == KIND_TABLE_WRITE) begin
				offsets[it.index] = it.value;
				expected_positions.push_back(r);
				return;
			end
			if (it.poll) begin
				seg          = it.reading[15:9];
				lo           = offsets[seg];
				hi           = offsets[(seg + 1) % TABLE_ENTRIES];
				frac         = it.reading[8:0];
				held_reading = it.reading;
				held_offset  = 16'(lo + (((hi - lo) * frac) >>> FRAC_W));
			end
			count  = held_reading;
			count  = count + held_offset;
			angle  = 16'(count - mech_zero);
			eangle = 16'((count - elec_zero) * pole_pairs);
			d = int'(angle) - int'(last_angle);
			t = turns;
			if (d > 32768) t = t - 16'd1;
			else if (d < -32768) t = t + 16'd1;
			if (!primed) begin
				t      = '0;
				primed = 1'b1;
			end
			turns      = t;
			last_angle = angle;
			mt = {t, angle};
			for (int i = 0; i < HISTORY_DEPTH - 1; i++) history[i] = history[i + 1];
			history[HISTORY_DEPTH - 1] = mt;
			delta = longint'(history[HISTORY_DEPTH - 1]) - longint'(history[0]);
			mag   = (delta < 0) ? -delta : delta;
			if (mag < longint'(deadband)) delta = 0;
			vel  = delta * longint'(inv_time[31:16])
			     + ((delta * longint'(inv_time[15:0])) >>> 16);
			evel = vel * longint'(pole_pairs);
			r.linear_count        = count[COUNT_W-1:0];
			r.mech_angle          = angle;
			r.electrical_angle    = eangle;
			r.turn_count          = t;
			r.multiturn_position  = mt;
			r.mech_velocity       = clamp32(vel);
			r.electrical_velocity = clamp32(evel);
			expected_positions.push_back(r);
		endfunction

		function void compare(string field, logic [63:0] want, logic [63:0] seen);
			if (want !== seen) begin
				$error("%s: expected %0d, got %0d", field, $signed(want), $signed(seen));
				mismatches++;
			end
		endfunction

		function void check_report(position_report_t got);
			position_report_t want;
			if (expected_positions.size() == 0) begin
				$error("result beat with no item outstanding");
				mismatches++;
				return;
			end
			want = expected_positions.pop_front();
			compare("linear_count", want.linear_count, got.linear_count);
			compare("mech_angle", want.mech_angle, got.mech_angle);
			compare("electrical_angle", want.electrical_angle, got.electrical_angle);
			compare("turn_count", want.turn_count, got.turn_count);
			compare("multiturn_position", want.multiturn_position, got.multiturn_position);
			compare("mech_velocity", want.mech_velocity, got.mech_velocity);
			compare("electrical_velocity", want.electrical_velocity,
				got.electrical_velocity);
		endfunction

		function int pending();
			return expected_positions.size();
		endfunction

		function int failures();
			return mismatches;
		endfunction

	endclass

endpackage

// ----- tb/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: encoder position and velocity tracker testbench
// Directed beats hit table extremes, index wrap, held-reading reuse and the
// half-turn edges; random phases then sweep register settings while the
// shaft turns in small, large and near half-turn steps. Sender bursts and
// receiver stalls vary per phase; every report is checked in order.
// ----------------------------------------------------------------------------
module tb;

	import ept_pkg::*;
	import tracker_check_pkg::*;

	localparam int ITEMS        = 1550;
	localparam int NUM_PHASES   = 8;
	localparam int LIMIT        = 500000;
	localparam int DRAIN_CYCLES = 20;

	logic                        clk;
	logic                        arst_n         = 1'b0;
	logic                        push           = 1'b0;
	logic                        full;
	logic                        func           = 1'b0;
	logic                        poll_sensor    = 1'b0;
	logic [READING_W-1:0]        sensor_reading = '0;
	logic [TABLE_AW-1:0]         table_index    = '0;
	logic signed [OFFSET_W-1:0]  table_value    = '0;
	logic                        empty;
	logic                        pop            = 1'b0;
	logic signed [COUNT_W-1:0]   linear_count;
	logic [ANGLE_W-1:0]          mech_angle;
	logic [ANGLE_W-1:0]          electrical_angle;
	logic signed [TURN_W-1:0]    turn_count;
	logic signed [POS_W-1:0]     multiturn_position;
	logic signed [VEL_W-1:0]     mech_velocity;
	logic signed [VEL_W-1:0]     electrical_velocity;
	logic                        cfg_we         = 1'b0;
	logic [CFG_AW-1:0]           cfg_addr       = '0;
	logic [CFG_DW-1:0]           cfg_wdata      = '0;

	position_checker sb = new();
	int              cycles  = 0;
	int              rx_mode = 0;
	int              rx_hold = 0;
	logic [15:0]     shaft   = '0;

	encoder_position_velocity_tracker u_top (
		.clk                 (clk),
		.arst_n              (arst_n),
		.push                (push),
		.full                (full),
		.func                (func),
		.poll_sensor         (poll_sensor),
		.sensor_reading      (sensor_reading),
		.table_index         (table_index),
		.table_value         (table_value),
		.empty               (empty),
		.pop                 (pop),
		.linear_count        (linear_count),
		.mech_angle          (mech_angle),
		.electrical_angle    (electrical_angle),
		.turn_count          (turn_count),
		.multiturn_position  (multiturn_position),
		.mech_velocity       (mech_velocity),
		.electrical_velocity (electrical_velocity),
		.cfg_we              (cfg_we),
		.cfg_addr            (cfg_addr),
		.cfg_wdata           (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT) begin
			$display("tb: FAIL");
			$finish;
		end
	end

	function automatic tracker_item_t make_item(kind_t kind, logic poll, logic [15:0] reading,
			logic [6:0] index, logic signed [15:0] value);
		tracker_item_t it;
		it.kind    = kind;
		it.poll    = poll;
		it.reading = reading;
		it.index   = index;
		it.value   = value;
		return it;
	endfunction

	always @(posedge clk) begin : watch
		position_report_t got;
		if (arst_n) begin
			if (pop && !empty) begin
				got = '{linear_count, mech_angle, electrical_angle, turn_count,
					multiturn_position, mech_velocity, electrical_velocity};
				sb.check_report(got);
			end
			if (push && !full) begin
				sb.accept_item(make_item(kind_t'(func), poll_sensor, sensor_reading,
					table_index, table_value));
			end
			if (cfg_we) begin
				sb.write_register(cfg_reg_t'(cfg_addr), cfg_wdata);
			end
		end
	end

	// result side: stall pattern set per phase
	initial begin
		forever begin
			@(posedge clk);
			if (rx_hold > 0) begin
				pop <= 1'b0;
				rx_hold--;
			end else begin
				pop <= 1'b1;
				case (rx_mode)
					1: rx_hold = ($urandom_range(9) < 3) ? $urandom_range(1, 2) : 0;
					2: rx_hold = ($urandom_range(19) == 0) ? $urandom_range(5, 40) : 0;
					3: rx_hold = $urandom_range(0, 3);
					default: rx_hold = 0;
				endcase
			end
		end
	end

	task automatic send_item(input tracker_item_t it);
		push           <= 1'b1;
		func           <= it.kind;
		poll_sensor    <= it.poll;
		sensor_reading <= it.reading;
		table_index    <= it.index;
		table_value    <= it.value;
		do @(posedge clk); while (full);
	endtask

	task automatic wait_drained();
		while (sb.pending() != 0) @(posedge clk);
	endtask

	task automatic configure(logic [15:0] mz, logic [15:0] ez, logic [6:0] pp,
			logic [15:0] db, logic [31:0] inv);
		cfg_reg_t    regs [5];
		logic [31:0] vals [5];
		regs = '{CFG_MECH_ZERO, CFG_ELEC_ZERO, CFG_POLE_PAIRS, CFG_DEADBAND, CFG_INV_TIME};
		vals = '{32'(mz), 32'(ez), 32'(pp), 32'(db), inv};
		for (int i = 0; i < 5; i++) begin
			cfg_we    <= 1'b1;
			cfg_addr  <= regs[i];
			cfg_wdata <= vals[i];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	function automatic tracker_item_t random_item();
		tracker_item_t it;
		int            roll;
		int            step;
		it = make_item(KIND_SAMPLE, 1'b1, 16'($urandom), 7'($urandom), 16'($urandom));
		roll = $urandom_range(99);
		if (roll < 8) begin
			it.kind = KIND_TABLE_WRITE;
			it.poll = 1'($urandom);
			case ($urandom_range(3))
				0: it.value = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
				1, 2: it.value = 16'(int'($urandom_range(0, 1024)) - 512);
				default: ;
			endcase
		end else if (roll < 16) begin
			it.poll = 1'b0;
		end else if (roll >= 20) begin
			case ($urandom_range(9))
				0, 1, 2, 3, 4: step = int'($urandom_range(0, 1200)) - 600;
				5, 6: step = int'($urandom_range(0, 32000)) - 16000;
				7, 8: step = ($urandom_range(1) ? 1 : -1) * int'($urandom_range(32760, 32776));
				default: step = int'($urandom_range(0, 65535));
			endcase
			shaft      = shaft + 16'(step);
			it.reading = shaft;
		end
		return it;
	endfunction

	task automatic run_random(int count);
		int left;
		int burst;
		left = count;
		while (left > 0) begin
			burst = $urandom_range(1, 24);
			for (int i = 0; i < burst && left > 0; i++) begin
				send_item(random_item());
				left--;
			end
			if (left == 0 || $urandom_range(99) < 70) begin
				push <= 1'b0;
				repeat ($urandom_range(1, 15)) @(posedge clk);
				if ($urandom_range(19) == 0) wait_drained();
			end
		end
	endtask

	task automatic run_directed();
		send_item(make_item(KIND_SAMPLE, 1'b0, 16'hFFFF, 7'd0, 16'sd0));
		send_item(make_item(KIND_TABLE_WRITE, 1'b0, 16'h0000, 7'd0, 16'sh8000));
		send_item(make_item(KIND_TABLE_WRITE, 1'b1, 16'hFFFF, 7'd127, 16'sh7FFF));
		send_item(make_item(KIND_TABLE_WRITE, 1'b0, 16'h0000, 7'd1, 16'sh7FFF));
		send_item(make_item(KIND_TABLE_WRITE, 1'b0, 16'h0000, 7'd64, -16'sd1));
		send_item(make_item(KIND_SAMPLE, 1'b1, 16'hFFFF, 7'd0, 16'sd0));
		send_item(make_item(KIND_SAMPLE, 1'b1, 16'h0000, 7'd0, 16'sd0));
		send_item(make_item(KIND_SAMPLE, 1'b1, 16'h01FF, 7'd0, 16'sd0));
		send_item(make_item(KIND_SAMPLE, 1'b1, 16'h0200, 7'd0, 16'sd0));
		send_item(make_item(KIND_SAMPLE, 1'b0, 16'h1234, 7'd127, 16'sd0));
		send_item(make_item(KIND_SAMPLE, 1'b1, 16'h8000, 7'd0, 16'sd0));
		// half-turn edges: exactly half a turn holds the count
		send_item(make_item(KIND_SAMPLE, 1'b1, 16'h4000, 7'd0, 16'sd0));
		send_item(make_item(KIND_SAMPLE, 1'b1, 16'hC000, 7'd0, 16'sd0));
		send_item(make_item(KIND_SAMPLE, 1'b1, 16'h4000, 7'd0, 16'sd0));
		send_item(make_item(KIND_SAMPLE, 1'b1, 16'hC001, 7'd0, 16'sd0));
		send_item(make_item(KIND_SAMPLE, 1'b1, 16'h4000, 7'd0, 16'sd0));
		send_item(make_item(KIND_SAMPLE, 1'b1, 16'h7FFF, 7'd0, 16'sd0));
		send_item(make_item(KIND_TABLE_WRITE, 1'b0, 16'h0000, 7'd127, 16'sh5A5A));
		send_item(make_item(KIND_SAMPLE, 1'b1, 16'hFE00, 7'd0, 16'sd0));
		push <= 1'b0;
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_directed();
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			wait_drained();
			case (ph)
				0: configure(16'd0, 16'd0, 7'd1, 16'd0, 32'h0001_0000);
				1: configure(16'hFFFF, 16'hFFFF, 7'd64, 16'hFFFF, 32'hFFFF_FFFF);
				2: configure(16'($urandom), 16'($urandom), 7'd0, 16'($urandom_range(0, 300)), '0);
				3: configure(16'($urandom), 16'($urandom), 7'd1, 16'd0, 32'hFFFF_FFFF);
				default: configure(16'($urandom), 16'($urandom), 7'($urandom_range(1, 64)),
					($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 2000)),
					($urandom_range(1) == 0) ? $urandom : $urandom_range(0, 1 << 20));
			endcase
			rx_mode = ph % 4;
			run_random(ITEMS / NUM_PHASES);
		end
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.failures() == 0 && sb.pending() == 0) begin
			$display("tb: PASS");
		end else begin
			$display("tb: FAIL");
		end
		$finish;
	end

endmodule
